@@ sv/round_robin_alarm_test_generator_assert.svh @@
// assertion macros for the alarm test generator
`ifndef ROUND_ROBIN_ALARM_TEST_GENERATOR_ASSERT_SVH
`define ROUND_ROBIN_ALARM_TEST_GENERATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RRAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define RRAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/rrat_pkg.sv @@
package rrat_pkg;

  localparam int NUM_CH    = 4;
  localparam int CH_W      = 2;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 4;
  localparam int SEV_W     = 2;
  localparam int PHASE_W   = 2;

  localparam logic [TIME_W-1:0] HOLDOFF_MS = 32'd2000;

  localparam logic [SEV_W-1:0] SEV_RAISED  = 2'd3;
  localparam logic [SEV_W-1:0] SEV_CLEARED = 2'd0;

  // scheduler phase
  localparam logic [PHASE_W-1:0] SP_INIT = 2'd0;
  localparam logic [PHASE_W-1:0] SP_SCAN = 2'd1;
  localparam logic [PHASE_W-1:0] SP_HOLD = 2'd2;

  // per-channel phase
  localparam logic [PHASE_W-1:0] CP_INIT   = 2'd0;
  localparam logic [PHASE_W-1:0] CP_IDLE   = 2'd1;
  localparam logic [PHASE_W-1:0] CP_WAIT   = 2'd2;
  localparam logic [PHASE_W-1:0] CP_RAISED = 2'd3;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION_BASE = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT         = 4'd8;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [TIME_W-1:0]  deadline;
  } chan_state_t;

  typedef struct packed {
    chan_state_t      state;
    logic             emit;
    logic [SEV_W-1:0] sev;
  } serve_t;

  function automatic logic [CFG_W-1:0] interval_reset(input logic [CH_W-1:0] ch);
    logic [CFG_W-1:0] v;
    case (ch)
      2'd0:    v = 24'd44000;
      2'd1:    v = 24'd64000;
      2'd2:    v = 24'd111000;
      default: v = 24'd133000;
    endcase
    return v;
  endfunction

  function automatic logic [CFG_W-1:0] duration_reset(input logic [CH_W-1:0] ch);
    logic [CFG_W-1:0] v;
    case (ch)
      2'd1:    v = 24'd8000;
      default: v = 24'd10000;
    endcase
    return v;
  endfunction

endpackage

@@ sv/rrat_if.sv @@
interface rrat_req_if import rrat_pkg::*;;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_ms;
  modport source (output valid, output now_ms, input ready);
  modport sink   (input valid, input now_ms, output ready);
endinterface

interface rrat_rsp_if import rrat_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  channel;
  logic [SEV_W-1:0] severity;
  modport source (output valid, output channel, output severity, input ready);
  modport sink   (input valid, input channel, input severity, output ready);
endinterface

interface rrat_cfg_if import rrat_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/rrat_serve.sv @@
module rrat_serve import rrat_pkg::*; (
  input  chan_state_t       cur,
  input  logic [TIME_W-1:0] now_ms,
  input  logic [CFG_W-1:0]  interval,
  input  logic [CFG_W-1:0]  duration,
  output serve_t            res
);

  logic [TIME_W-1:0] arm_dl;
  logic [TIME_W-1:0] raise_dl;

  assign arm_dl   = now_ms + {{(TIME_W-CFG_W){1'b0}}, interval};
  assign raise_dl = now_ms + {{(TIME_W-CFG_W){1'b0}}, duration};

  always_comb begin
    res       = '0;
    res.state = cur;
    res.sev   = SEV_CLEARED;
    case (cur.phase)
      CP_INIT: begin
        res.state.phase = CP_IDLE;
      end
      CP_IDLE: begin
        // arm, and test the fresh deadline at once
        res.state.phase    = CP_WAIT;
        res.state.deadline = arm_dl;
        if (now_ms > arm_dl) begin
          res.state.phase    = CP_RAISED;
          res.state.deadline = raise_dl;
          res.emit           = 1'b1;
          res.sev            = SEV_RAISED;
        end
      end
      CP_WAIT: begin
        if (now_ms > cur.deadline) begin
          res.state.phase    = CP_RAISED;
          res.state.deadline = raise_dl;
          res.emit           = 1'b1;
          res.sev            = SEV_RAISED;
        end
      end
      default: begin
        // raised: clear without rearming
        if (now_ms > cur.deadline) begin
          res.state.phase = CP_IDLE;
          res.emit        = 1'b1;
          res.sev         = SEV_CLEARED;
        end
      end
    endcase
  end

endmodule

@@ sv/round_robin_alarm_test_generator.sv @@
// a request beat lands in the input register and is served combinationally; when it
// makes a message, the result register is loaded from it once the result side can take it
// one request beat per cycle while the result side is not holding a message back,
// set by the combinational serve path between the input register and the result register
// reset (rst, synchronous): scheduler and every channel back to init, interval and
// duration registers back to their defaults, both registers emptied
module round_robin_alarm_test_generator import rrat_pkg::*; (
  input logic       clk,
  input logic       rst,
  rrat_req_if.sink  req,
  rrat_rsp_if.source rsp,
  rrat_cfg_if.sink  cfg
);

  // configuration registers
  logic [CFG_W-1:0] interval [NUM_CH];
  logic [CFG_W-1:0] duration [NUM_CH];

  // scheduler state
  logic [PHASE_W-1:0] scan_phase;
  logic [TIME_W-1:0]  holdoff_deadline;
  logic [CH_W-1:0]    scan_index;

  // channel state
  logic [PHASE_W-1:0] chan_phase    [NUM_CH];
  logic [TIME_W-1:0]  chan_deadline [NUM_CH];

  // input register
  logic              req_vld;
  logic [TIME_W-1:0] req_now;

  // result register
  logic             rsp_vld;
  logic [CH_W-1:0]  rsp_chan;
  logic [SEV_W-1:0] rsp_sev;

  chan_state_t cur;
  serve_t      srv;
  logic        emit_now;
  logic        advance;

  // channel picked by the round-robin pointer
  assign cur.phase    = chan_phase[scan_index];
  assign cur.deadline = chan_deadline[scan_index];

  rrat_serve u_serve (
    .cur      (cur),
    .now_ms   (req_now),
    .interval (interval[scan_index]),
    .duration (duration[scan_index]),
    .res      (srv)
  );

  // only a scanning beat can produce a message
  assign emit_now = (scan_phase == SP_SCAN) && srv.emit;

  // a beat that makes no message never waits on the result side
  assign advance   = req_vld && (!rsp_vld || rsp.ready || !emit_now);
  assign req.ready = !req_vld || advance;

  assign rsp.valid    = rsp_vld;
  assign rsp.channel  = rsp_chan;
  assign rsp.severity = rsp_sev;

  // configuration writes are taken at any time
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        interval[i] <= interval_reset(CH_W'(i));
        duration[i] <= duration_reset(CH_W'(i));
      end
    end else if (cfg.valid) begin
      // writes past the register map are dropped
      if (cfg.index < REG_DURATION_BASE) begin
        interval[cfg.index[CH_W-1:0]] <= cfg.data;
      end else if (cfg.index < REG_COUNT) begin
        duration[cfg.index[CH_W-1:0]] <= cfg.data;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else if (req.ready) begin
      req_vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_now <= req.now_ms;
    end
  end

  // scheduler and channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase       <= SP_INIT;
      holdoff_deadline <= '0;
      scan_index       <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        chan_phase[i]    <= CP_INIT;
        chan_deadline[i] <= '0;
      end
    end else if (advance) begin
      case (scan_phase)
        SP_INIT: begin
          scan_phase <= SP_SCAN;
        end
        SP_SCAN: begin
          scan_index                <= scan_index + CH_W'(1);
          chan_phase[scan_index]    <= srv.state.phase;
          chan_deadline[scan_index] <= srv.state.deadline;
          if (srv.emit) begin
            scan_phase       <= SP_HOLD;
            holdoff_deadline <= req_now + HOLDOFF_MS;
          end
        end
        SP_HOLD: begin
          // the beat that ends the holdoff serves nobody
          if (req_now > holdoff_deadline) begin
            scan_phase <= SP_SCAN;
          end
        end
        default: begin
          scan_phase <= SP_SCAN;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (advance && emit_now) begin
      rsp_vld <= 1'b1;
    end else if (rsp.ready) begin
      rsp_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit_now) begin
      rsp_chan <= scan_index;
      rsp_sev  <= srv.sev;
    end
  end

`include "round_robin_alarm_test_generator_assert.svh"

  // every message opens a holdoff
  `RRAT_ASSERT_NEXT(a_emit_holds, advance && emit_now, scan_phase == SP_HOLD, "no holdoff after message")
  // a message is never loaded over one still waiting
  `RRAT_ASSERT_NOW(a_no_overwrite, advance && emit_now && rsp_vld, rsp.ready, "result overwritten")
  // pointer moves by one on every scanning beat
  `RRAT_ASSERT_NEXT(a_rr_step, advance && scan_phase == SP_SCAN, scan_index == $past(scan_index) + 2'd1, "round-robin skip")
  // pointer stays outside scanning
  `RRAT_ASSERT_NEXT(a_rr_hold, !(advance && scan_phase == SP_SCAN), $stable(scan_index), "pointer moved off scan")

endmodule

@@ tb/rrat_alarm_checker.sv @@
module rrat_alarm_checker import rrat_pkg::*; (
  input  logic clk,
  input  logic rst,
  rrat_req_if  req,
  rrat_rsp_if  rsp,
  rrat_cfg_if  cfg,
  output int   mismatches,
  output int   alarms_due,
  output int   ticks_seen,
  output int   raised_seen,
  output int   cleared_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [SEV_W-1:0] severity;
  } alarm_msg_t;

  logic [CFG_W-1:0]   interval_ms [NUM_CH];
  logic [CFG_W-1:0]   duration_ms [NUM_CH];
  logic [PHASE_W-1:0] sched_phase;
  logic [TIME_W-1:0]  holdoff_end;
  logic [CH_W-1:0]    next_ch;
  logic [PHASE_W-1:0] ch_phase [NUM_CH];
  logic [TIME_W-1:0]  ch_deadline [NUM_CH];
  alarm_msg_t         due_msgs [$];

  function automatic void restore_defaults();
    interval_ms[0] = 24'd44000;
    interval_ms[1] = 24'd64000;
    interval_ms[2] = 24'd111000;
    interval_ms[3] = 24'd133000;
    duration_ms[0] = 24'd10000;
    duration_ms[1] = 24'd8000;
    duration_ms[2] = 24'd10000;
    duration_ms[3] = 24'd10000;
    for (int i = 0; i < NUM_CH; i++) begin
      ch_phase[i]    = CP_INIT;
      ch_deadline[i] = '0;
    end
    sched_phase = SP_INIT;
    holdoff_end = '0;
    next_ch     = '0;
  endfunction

  function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] value);
    if (idx < REG_DURATION_BASE)
      interval_ms[idx[CH_W-1:0]] = value;
    else if (idx < REG_COUNT)
      duration_ms[idx[CH_W-1:0]] = value;
  endfunction

  // one service of a channel, returns 1 when it emits a message
  function automatic bit serve_channel(input logic [CH_W-1:0] ch,
                                       input logic [TIME_W-1:0] now,
                                       output logic [SEV_W-1:0] sev);
    bit fired;
    fired = 1'b0;
    sev   = SEV_CLEARED;
    case (ch_phase[ch])
      CP_INIT: ch_phase[ch] = CP_IDLE;
      CP_IDLE, CP_WAIT: begin
        // arming tests the fresh deadline in the same call
        if (ch_phase[ch] == CP_IDLE) begin
          ch_phase[ch]    = CP_WAIT;
          ch_deadline[ch] = now + interval_ms[ch];
        end
        if (now > ch_deadline[ch]) begin
          ch_deadline[ch] = now + duration_ms[ch];
          ch_phase[ch]    = CP_RAISED;
          sev             = SEV_RAISED;
          fired           = 1'b1;
        end
      end
      default: begin
        if (now > ch_deadline[ch]) begin
          ch_phase[ch] = CP_IDLE;
          sev          = SEV_CLEARED;
          fired        = 1'b1;
        end
      end
    endcase
    return fired;
  endfunction

  function automatic void schedule_tick(input logic [TIME_W-1:0] now);
    logic [CH_W-1:0]  ch;
    logic [SEV_W-1:0] sev;
    alarm_msg_t       msg;
    case (sched_phase)
      SP_INIT: sched_phase = SP_SCAN;
      SP_SCAN: begin
        ch      = next_ch;
        next_ch = ch + 1'b1;
        if (serve_channel(ch, now, sev)) begin
          sched_phase  = SP_HOLD;
          holdoff_end  = now + HOLDOFF_MS;
          msg.channel  = ch;
          msg.severity = sev;
          due_msgs.push_back(msg);
        end
      end
      SP_HOLD: begin
        if (now > holdoff_end)
          sched_phase = SP_SCAN;
      end
      default: sched_phase = SP_SCAN;
    endcase
  endfunction

  always @(posedge clk) begin
    alarm_msg_t want;
    if (rst) begin
      restore_defaults();
      due_msgs.delete();
      mismatches   = 0;
      ticks_seen   = 0;
      raised_seen  = 0;
      cleared_seen = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (due_msgs.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected alarm beat, expected none, got channel %0d severity %0d",
                   $time, rsp.channel, rsp.severity);
        end else begin
          want = due_msgs.pop_front();
          if (rsp.channel !== want.channel) begin
            mismatches++;
            $display("%0t: channel mismatch, expected %0d, got %0d",
                     $time, want.channel, rsp.channel);
          end
          if (rsp.severity !== want.severity) begin
            mismatches++;
            $display("%0t: severity mismatch, expected %0d, got %0d",
                     $time, want.severity, rsp.severity);
          end
        end
        if (rsp.severity == SEV_RAISED)
          raised_seen++;
        else
          cleared_seen++;
      end
      if (cfg.valid && cfg.ready)
        write_register(cfg.index, cfg.data);
      if (req.valid && req.ready) begin
        schedule_tick(req.now_ms);
        ticks_seen++;
      end
    end
    alarms_due = due_msgs.size();
  end

endmodule

@@ tb/tb_round_robin_alarm_test_generator.sv @@
module tb_round_robin_alarm_test_generator;
  import rrat_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no beat on any channel before the run is called hung
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;

  rrat_req_if req_bus ();
  rrat_rsp_if rsp_bus ();
  rrat_cfg_if cfg_bus ();

  int mismatches;
  int alarms_due;
  int ticks_seen;
  int raised_seen;
  int cleared_seen;

  logic [TIME_W-1:0] wall_ms;
  logic [TIME_W-1:0] opening_ticks [23];
  bit                send_quiet;
  bit                rsp_quiet;
  int                writes_done;
  int                idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  round_robin_alarm_test_generator dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  rrat_alarm_checker alarm_check (
    .clk          (clk),
    .rst          (rst),
    .req          (req_bus),
    .rsp          (rsp_bus),
    .cfg          (cfg_bus),
    .mismatches   (mismatches),
    .alarms_due   (alarms_due),
    .ticks_seen   (ticks_seen),
    .raised_seen  (raised_seen),
    .cleared_seen (cleared_seen)
  );

  // one scheduler tick; valid stays up so back-to-back ticks need no extra edge
  task automatic send_tick(input logic [TIME_W-1:0] now);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.valid  <= 1'b1;
    req_bus.now_ms <= now;
    do @(posedge clk); while (!(req_bus.valid && req_bus.ready));
    @(negedge clk);
  endtask

  // register beat; the caller lowers valid once the burst is done
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    @(negedge clk);
    writes_done++;
  endtask

  // every interval and duration drawn from lo..hi
  task automatic program_all(input int unsigned lo, input int unsigned hi);
    for (int i = 0; i < NUM_CH; i++) begin
      write_reg(REG_INTERVAL_BASE + CFG_IDX_W'(i), CFG_W'($urandom_range(lo, hi)));
      write_reg(REG_DURATION_BASE + CFG_IDX_W'(i), CFG_W'($urandom_range(lo, hi)));
    end
  endtask

  // hold ticks back until every alarm has come out, then let the pipe run dry
  task automatic settle();
    req_bus.valid <= 1'b0;
    while (alarms_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mostly forward-moving time with random steps, some jumps and near-wrap values
  task automatic run_random(input int count, input int unsigned step_cap);
    cfg_bus.valid <= 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0)
        send_quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 15))
        0:       wall_ms = $urandom();
        1:       wall_ms = {TIME_W{1'b1}} - $urandom_range(0, step_cap);
        default: wall_ms = wall_ms + $urandom_range(0, step_cap);
      endcase
      send_tick(wall_ms);
    end
  endtask

  // result side: random stall before each beat, with stall-free stretches
  initial begin
    int stall;
    int served;
    rsp_bus.ready = 1'b0;
    rsp_quiet     = 1'b0;
    served        = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (served % 24 == 0)
        rsp_quiet = ($urandom_range(0, 3) == 0);
      stall = rsp_quiet ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_bus.valid && rsp_bus.ready));
      served++;
      @(negedge clk);
    end
  end

  // watchdog on beats of any channel
  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("round_robin_alarm_test_generator verification failed");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    req_bus.valid  = 1'b0;
    req_bus.now_ms = '0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = '0;
    cfg_bus.data   = '0;
    wall_ms        = '0;
    send_quiet     = 1'b0;
    writes_done    = 0;

    // directed ticks on reset defaults:
    // leave init, init each channel, arm ch0, arm ch1 with a wrapping deadline so it
    // fires at once, holdoff end at max time, arm ch2/ch3, raise ch0, holdoff edge
    // (equal then greater), clear ch1 off a wrapped deadline, raise ch2 and ch3,
    // clear ch0, rearm ch1, clear ch2
    opening_ticks = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                      32'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd20, 32'd30,
                      32'd44011, 32'd46011, 32'd46012, 32'd46013, 32'd60000,
                      32'd200000, 32'd202001, 32'd202002, 32'd300000, 32'd300001,
                      32'd302002, 32'd302003, 32'd302004};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < 23; i++)
      send_tick(opening_ticks[i]);
    wall_ms = opening_ticks[22];

    // short intervals against steps near the holdoff
    settle();
    program_all(0, 3000);
    run_random(110, 1500);

    // everything zero, plus writes past the register map that must not land
    settle();
    program_all(0, 0);
    write_reg(REG_COUNT, CFG_W'($urandom()));
    write_reg({CFG_IDX_W{1'b1}}, CFG_W'($urandom()));
    run_random(110, 1200);

    // everything at the top of the range, big time steps
    settle();
    program_all(24'hFF_FFFF, 24'hFF_FFFF);
    run_random(110, 24'hFF_FFFF);

    // full-range settings
    settle();
    program_all(0, 24'hFF_FFFF);
    run_random(110, 32'd1 << 22);

    // tight settings, with a full drain halfway
    settle();
    program_all(0, 500);
    run_random(55, 800);
    settle();
    run_random(55, 800);

    req_bus.valid <= 1'b0;
    while (alarms_due != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d ticks, %0d raised and %0d cleared alarms, %0d register writes",
             ticks_seen, raised_seen, cleared_seen, writes_done);
    $display("settings: reset defaults, short, all zero, all max, full range, tight");
    if (mismatches == 0)
      $display("round_robin_alarm_test_generator verification clean");
    else
      $display("round_robin_alarm_test_generator verification failed");
    $finish;
  end

endmodule

@@ round_robin_alarm_test_generator.f @@
+incdir+sv
sv/rrat_pkg.sv
sv/rrat_if.sv
sv/rrat_serve.sv
sv/round_robin_alarm_test_generator.sv
tb/rrat_alarm_checker.sv
tb/tb_round_robin_alarm_test_generator.sv
